// ----- rtl/lbbh_pkg.sv -----
package lbbh_pkg;

  // table and field sizes
  localparam int LABEL_COUNT = 256;
  localparam int IDX_W       = $clog2(LABEL_COUNT);
  localparam int LABEL_W     = 8;
  localparam int OP_W        = 2;
  localparam int COORD_BITS  = 10;
  localparam int EXTENT_W    = COORD_BITS + 1;
  localparam int COUNT_BITS  = 30;
  localparam int AXES        = 3;

  // operation codes, code three is unused
  typedef enum logic [OP_W-1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [EXTENT_W-1:0]   extent_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // one label's stored statistics
  typedef struct packed {
    count_t               count;
    coord_t [AXES-1:0]    lo;
    coord_t [AXES-1:0]    hi;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // read response
  typedef struct packed {
    logic                 present;
    count_t               total;
    coord_t  [AXES-1:0]   low;
    extent_t [AXES-1:0]   extent;
  } result_t;

  // update stage output toward the table and the result register
  typedef struct packed {
    logic    wr_en;
    entry_t  wr_entry;
    result_t res;
  } upd_t;

endpackage

// ----- rtl/lbbh_ram.sv -----
module lbbh_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // single write port, registered read returns old data on a collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/lbbh_update.sv -----
module lbbh_update
  import lbbh_pkg::*;
(
  input  logic [OP_W-1:0]    op_i,
  input  logic [LABEL_W-1:0] label_i,
  input  coord_t             coord_x_i,
  input  coord_t             coord_y_i,
  input  coord_t             coord_z_i,
  input  logic               seen_i,
  input  entry_t             entry_i,
  output upd_t               upd_o
);

  logic              label_ok;
  coord_t [AXES-1:0] pt;
  count_t            cnt_inc;

  assign label_ok = (label_i != '0) && (int'(label_i) < LABEL_COUNT);
  assign pt[0]    = coord_x_i;
  assign pt[1]    = coord_y_i;
  assign pt[2]    = coord_z_i;

  // saturating count
  assign cnt_inc = (entry_i.count == '1) ? entry_i.count : entry_i.count + count_t'(1);

  always_comb begin
    // merge the voxel into the entry, or start a fresh one
    upd_o.wr_en          = (op_i == OP_ACCUM) && label_ok;
    upd_o.wr_entry.count = seen_i ? cnt_inc : count_t'(1);
    for (int a = 0; a < AXES; a++) begin
      if (!seen_i) begin
        upd_o.wr_entry.lo[a] = pt[a];
        upd_o.wr_entry.hi[a] = pt[a];
      end else begin
        upd_o.wr_entry.lo[a] = (pt[a] < entry_i.lo[a]) ? pt[a] : entry_i.lo[a];
        upd_o.wr_entry.hi[a] = (pt[a] > entry_i.hi[a]) ? pt[a] : entry_i.hi[a];
      end
    end

    // read response, absent labels report all zero
    upd_o.res = '0;
    if (label_ok && seen_i) begin
      upd_o.res.present = 1'b1;
      upd_o.res.total   = entry_i.count;
      for (int a = 0; a < AXES; a++) begin
        upd_o.res.low[a]    = entry_i.lo[a];
        upd_o.res.extent[a] = {1'b0, entry_i.hi[a]} - {1'b0, entry_i.lo[a]} + extent_t'(1);
      end
    end
  end

endmodule

// ----- rtl/label_bounding_box_histogram.sv -----
// Per-label voxel count and bounding box. One transaction is taken every cycle
// unless the input is stalled: the label table read is issued from the input
// port as the transaction is accepted, and in the following cycle the entry is
// merged and written back, a back-to-back update of the same label being
// forwarded around the table. A read result passes from the input stage into
// the output register; accumulate and clear give no result. Presence bits are
// flip-flops, so one clear empties every label together and reset needs no
// clearing pass. Only a read waiting on a full output register stalls the input.
module label_bounding_box_histogram
  import lbbh_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [LABEL_W-1:0]  voxel_label_i,
  input  logic [COORD_BITS-1:0] coord_x_i,
  input  logic [COORD_BITS-1:0] coord_y_i,
  input  logic [COORD_BITS-1:0] coord_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                present_o,
  output logic [COUNT_BITS-1:0] voxel_total_o,
  output logic [COORD_BITS-1:0] low_x_o,
  output logic [COORD_BITS-1:0] low_y_o,
  output logic [COORD_BITS-1:0] low_z_o,
  output logic [EXTENT_W-1:0] extent_x_o,
  output logic [EXTENT_W-1:0] extent_y_o,
  output logic [EXTENT_W-1:0] extent_z_o
);

  logic                   s1_valid_q;
  logic [OP_W-1:0]        s1_op_q;
  logic [LABEL_W-1:0]     s1_label_q;
  coord_t                 s1_x_q, s1_y_q, s1_z_q;
  logic                   byp_hit_q;
  entry_t                 byp_entry_q;
  logic [LABEL_COUNT-1:0] seen_q;
  logic                   out_valid_q;
  result_t                res_q;

  logic                   accept;
  logic                   s1_is_read;
  logic                   s1_fire;
  logic                   wr_en;
  logic [IDX_W-1:0]       s1_idx;
  logic [ENTRY_W-1:0]     ram_rdata;
  entry_t                 entry_cur;
  upd_t                   upd;

  // stage handshake
  assign s1_is_read = (s1_op_q == OP_READ);
  assign s1_fire    = s1_valid_q && (!s1_is_read || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign accept     = in_valid_i && in_ready_o;
  assign s1_idx     = s1_label_q[IDX_W-1:0];
  assign wr_en      = s1_fire && upd.wr_en;

  // label table
  lbbh_ram #(
    .Width (ENTRY_W),
    .Depth (LABEL_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_idx),
    .wdata_i (upd.wr_entry),
    .re_i    (accept),
    .raddr_i (voxel_label_i[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // forward a write that collided with this item's table read
  assign entry_cur = byp_hit_q ? byp_entry_q : entry_t'(ram_rdata);

  lbbh_update u_update (
    .op_i      (s1_op_q),
    .label_i   (s1_label_q),
    .coord_x_i (s1_x_q),
    .coord_y_i (s1_y_q),
    .coord_z_i (s1_z_q),
    .seen_i    (seen_q[s1_idx]),
    .entry_i   (entry_cur),
    .upd_o     (upd)
  );

  // input stage and forwarding registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        byp_hit_q  <= wr_en && (s1_label_q == voxel_label_i);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= operation_i;
      s1_label_q  <= voxel_label_i;
      s1_x_q      <= coord_x_i;
      s1_y_q      <= coord_y_i;
      s1_z_q      <= coord_z_i;
      byp_entry_q <= upd.wr_entry;
    end
  end

  // presence bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (s1_fire && (s1_op_q == OP_CLEAR)) begin
      seen_q <= '0;
    end else if (wr_en) begin
      seen_q[s1_idx] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_is_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_is_read) begin
      res_q <= upd.res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign present_o     = res_q.present;
  assign voxel_total_o = res_q.total;
  assign low_x_o       = res_q.low[0];
  assign low_y_o       = res_q.low[1];
  assign low_z_o       = res_q.low[2];
  assign extent_x_o    = res_q.extent[0];
  assign extent_y_o    = res_q.extent[1];
  assign extent_z_o    = res_q.extent[2];

  // a clear leaves every label absent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (s1_op_q == OP_CLEAR) |=> seen_q == '0)
    else $error("labels remain present after clear");

  // forwarding only follows a table write in the previous cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(byp_hit_q) |-> $past(wr_en))
    else $error("forwarding without a colliding write");

  // a present label has a nonzero count and x and z extent, an absent one zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (present_o == (voxel_total_o != '0))
                 && (present_o == (extent_x_o != '0))
                 && (present_o == (extent_z_o != '0)))
    else $error("read result inconsistent with presence");

  // only reads produce results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_fire && s1_is_read))
    else $error("result without a read transaction");

endmodule

// ----- tb/tb_label_bounding_box_histogram.sv -----
module tb_label_bounding_box_histogram;
  import lbbh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // operation code three is not decoded by the block
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_IDLE = 11;
  localparam int DRAIN_LIMIT = 4000;
  localparam coord_t COORD_TOP = '1;

  // one read response, axis 0 is x, 1 is y, 2 is z
  typedef struct packed {
    logic                present;
    count_t              total;
    coord_t  [AXES-1:0]  low;
    extent_t [AXES-1:0]  extent;
  } read_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [OP_W-1:0]       operation_i;
  logic [LABEL_W-1:0]    voxel_label_i;
  coord_t                coord_x_i;
  coord_t                coord_y_i;
  coord_t                coord_z_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  present_o;
  count_t                voxel_total_o;
  coord_t                low_x_o;
  coord_t                low_y_o;
  coord_t                low_z_o;
  extent_t               extent_x_o;
  extent_t               extent_y_o;
  extent_t               extent_z_o;

  // shadow label table
  bit                    label_seen [LABEL_COUNT];
  count_t                label_voxels [LABEL_COUNT];
  coord_t                box_lo [LABEL_COUNT][AXES];
  coord_t                box_hi [LABEL_COUNT][AXES];

  read_result_t          pending_reads[$];
  logic [LABEL_W-1:0]    hot_labels [8];

  bit                    tx_idle;
  bit                    rx_idle;
  int                    rx_hold;
  int                    mismatches;
  int                    items_sent;
  int                    reads_checked;
  int                    clears_sent;

  label_bounding_box_histogram uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .voxel_label_i (voxel_label_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .present_o     (present_o),
    .voxel_total_o (voxel_total_o),
    .low_x_o       (low_x_o),
    .low_y_o       (low_y_o),
    .low_z_o       (low_z_o),
    .extent_x_o    (extent_x_o),
    .extent_y_o    (extent_y_o),
    .extent_z_o    (extent_z_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(2_000_000);
    $display("FAIL label_bounding_box_histogram");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // apply one accepted transaction to the shadow table, queue a read response
  task automatic update_label_table(input logic [OP_W-1:0] op,
                                    input logic [LABEL_W-1:0] label,
                                    input coord_t x, input coord_t y, input coord_t z);
    coord_t       pt [AXES];
    read_result_t want;
    bit           valid_label;
    pt[0] = x;
    pt[1] = y;
    pt[2] = z;
    valid_label = (label != '0) && (int'(label) < LABEL_COUNT);
    case (op)
      OP_ACCUM: begin
        if (valid_label) begin
          if (!label_seen[label]) begin
            label_seen[label] = 1'b1;
            label_voxels[label] = count_t'(1);
            for (int a = 0; a < AXES; a++) begin
              box_lo[label][a] = pt[a];
              box_hi[label][a] = pt[a];
            end
          end else begin
            // count saturates at all ones
            if (label_voxels[label] != '1) label_voxels[label]++;
            for (int a = 0; a < AXES; a++) begin
              if (pt[a] < box_lo[label][a]) box_lo[label][a] = pt[a];
              if (pt[a] > box_hi[label][a]) box_hi[label][a] = pt[a];
            end
          end
        end
      end
      OP_READ: begin
        want = '0;
        if (valid_label && label_seen[label]) begin
          want.present = 1'b1;
          want.total = label_voxels[label];
          for (int a = 0; a < AXES; a++) begin
            want.low[a] = box_lo[label][a];
            want.extent[a] = {1'b0, box_hi[label][a]} - {1'b0, box_lo[label][a]}
                             + extent_t'(1);
          end
        end
        pending_reads.push_back(want);
      end
      OP_CLEAR: begin
        for (int i = 0; i < LABEL_COUNT; i++) label_seen[i] = 1'b0;
        clears_sent++;
      end
      default: begin
      end
    endcase
  endtask

  // offer one transaction and hold it until accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [LABEL_W-1:0] label,
                           input coord_t x, input coord_t y, input coord_t z);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    voxel_label_i <= label;
    coord_x_i     <= x;
    coord_y_i     <= y;
    coord_z_i     <= z;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    update_label_table(op, label, x, y, z);
  endtask

  // stop offering and wait until every queued read response has come back or the drain limit runs out
  task automatic wait_for_results();
    int cycles;
    cycles = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reads.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
  endtask

  function automatic coord_t pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return COORD_TOP;
    return coord_t'($urandom_range(0, 1023));
  endfunction

  function automatic logic [LABEL_W-1:0] pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return hot_labels[$urandom_range(0, 7)];
    if (r < 90) return LABEL_W'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: return '0;
      1: return LABEL_W'(1);
      default: return '1;
    endcase
  endfunction

  task automatic refresh_hot_labels();
    foreach (hot_labels[i]) hot_labels[i] = LABEL_W'($urandom_range(1, 255));
  endtask

  // mostly voxels, reads at the given rate, rare clears and unused codes
  task automatic send_random_item(input int read_pct);
    int r;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 1) op = OP_CLEAR;
    else if (r < 3) op = OP_UNUSED;
    else if (r < 3 + read_pct) op = OP_READ;
    else op = OP_ACCUM;
    send_item(op, pick_label(), pick_coord(), pick_coord(), pick_coord());
  endtask

  // result sink with random stalls and an optional long hold-off
  initial begin : result_sink
    int wait_cycles;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      wait_cycles = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
      wait_cycles += rx_hold;
      rx_hold = 0;
      if (wait_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o && rx_hold == 0);
    end
  end

  // compare every accepted read response with the oldest prediction
  always @(posedge clk_i) begin : result_check
    read_result_t got;
    read_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.present   = present_o;
      got.total     = voxel_total_o;
      got.low[0]    = low_x_o;
      got.low[1]    = low_y_o;
      got.low[2]    = low_z_o;
      got.extent[0] = extent_x_o;
      got.extent[1] = extent_y_o;
      got.extent[2] = extent_z_o;
      if (pending_reads.size() == 0) begin
        report_mismatch("response with no read pending", 64'(got.total), '0);
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (got.present !== want.present)
          report_mismatch("present", 64'(got.present), 64'(want.present));
        if (got.total !== want.total)
          report_mismatch("voxel_total", 64'(got.total), 64'(want.total));
        for (int a = 0; a < AXES; a++) begin
          if (got.low[a] !== want.low[a])
            report_mismatch($sformatf("low axis %0d", a), 64'(got.low[a]),
                            64'(want.low[a]));
          if (got.extent[a] !== want.extent[a])
            report_mismatch($sformatf("extent axis %0d", a), 64'(got.extent[a]),
                            64'(want.extent[a]));
        end
      end
    end
  end

  // field extremes, every operation and the corner cases, back to back
  task automatic test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_item(OP_READ,   8'd0,   10'd0,    10'd0,    10'd0);
    send_item(OP_READ,   8'd255, 10'd0,    10'd0,    10'd0);
    send_item(OP_ACCUM,  8'd1,   10'd0,    10'd0,    10'd0);
    send_item(OP_ACCUM,  8'd1,   COORD_TOP, COORD_TOP, COORD_TOP);
    send_item(OP_READ,   8'd1,   10'd0,    10'd0,    10'd0);
    // label zero is ignored on accumulate and reads as absent
    send_item(OP_ACCUM,  8'd0,   10'd5,    10'd5,    10'd5);
    send_item(OP_READ,   8'd0,   COORD_TOP, COORD_TOP, COORD_TOP);
    send_item(OP_ACCUM,  8'd255, COORD_TOP, 10'd0,    10'd512);
    send_item(OP_ACCUM,  8'd255, 10'd0,    COORD_TOP, 10'd3);
    send_item(OP_ACCUM,  8'd255, 10'd700,  10'd700,  COORD_TOP);
    send_item(OP_READ,   8'd255, 10'd0,    10'd0,    10'd0);
    // unused code leaves the table alone
    send_item(OP_UNUSED, 8'd255, 10'd1,    10'd1,    10'd1);
    send_item(OP_READ,   8'd255, 10'd0,    10'd0,    10'd0);
    send_item(OP_ACCUM,  8'd128, 10'd10,   10'd20,   10'd30);
    send_item(OP_READ,   8'd128, 10'd0,    10'd0,    10'd0);
    send_item(OP_CLEAR,  8'd0,   10'd0,    10'd0,    10'd0);
    send_item(OP_READ,   8'd1,   10'd0,    10'd0,    10'd0);
    send_item(OP_READ,   8'd255, 10'd0,    10'd0,    10'd0);
    // first voxel after a clear restarts the box
    send_item(OP_ACCUM,  8'd255, 10'd5,    10'd6,    10'd7);
    send_item(OP_READ,   8'd255, 10'd0,    10'd0,    10'd0);
    send_item(OP_ACCUM,  8'd170, 10'd341,  10'd682,  10'd85);
    send_item(OP_ACCUM,  8'd170, 10'd682,  10'd341,  10'd938);
    send_item(OP_READ,   8'd170, 10'd0,    10'd0,    10'd0);
    wait_for_results();
  endtask

  // random traffic in phases with every combination of idling on both sides
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle = (phase == 0) || (phase == 2);
      rx_idle = (phase == 0) || (phase == 1);
      refresh_hot_labels();
      repeat (150) send_random_item(30);
      // sender pauses until every response is back
      wait_for_results();
    end
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    refresh_hot_labels();
    rx_hold = 80;
    repeat (60) send_random_item(70);
    wait_for_results();
  endtask

  // two labels hit back to back, stressing same-label update forwarding
  task automatic test_hot_label_updates();
    logic [LABEL_W-1:0] pair [2];
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    pair[0] = LABEL_W'($urandom_range(1, 255));
    pair[1] = LABEL_W'($urandom_range(1, 255));
    repeat (100) begin
      send_item(($urandom_range(0, 3) == 0) ? OP_READ : OP_ACCUM,
                pair[$urandom_range(0, 1)], pick_coord(), pick_coord(), pick_coord());
    end
    wait_for_results();
  endtask

  // stimulus sequence
  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    operation_i   = OP_ACCUM;
    voxel_label_i = '0;
    coord_x_i     = '0;
    coord_y_i     = '0;
    coord_z_i     = '0;
    tx_idle       = 1'b0;
    rx_idle       = 1'b0;
    rx_hold       = 0;
    mismatches    = 0;
    items_sent    = 0;
    reads_checked = 0;
    clears_sent   = 0;
    refresh_hot_labels();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic();
    test_output_backpressure();
    test_hot_label_updates();

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (pending_reads.size() != 0)
      report_mismatch("read responses never returned", 64'(pending_reads.size()), '0);

    $display("run covered %0d transactions with %0d clears; %0d read responses checked",
             items_sent, clears_sent, reads_checked);
    if (mismatches == 0) begin
      $display("PASS label_bounding_box_histogram");
    end else begin
      $display("FAIL label_bounding_box_histogram");
    end
    $finish;
  end

endmodule

// ----- label_bounding_box_histogram.f -----
rtl/lbbh_pkg.sv
rtl/lbbh_ram.sv
rtl/lbbh_update.sv
rtl/label_bounding_box_histogram.sv
tb/tb_label_bounding_box_histogram.sv
